FILE: src/kdlpr_pkg.sv
// Shared types and constants for the key debounce, long-press and repeat block.
// Used by the key lanes, the report merge stage and the top level.
package kdlpr_pkg;

	localparam int NUM_KEYS = 5;
	localparam int TYPE_W   = 2;
	localparam int CNT_W    = 8;
	localparam int TYPES_W  = NUM_KEYS * TYPE_W;
	localparam int CFG_W    = TYPES_W;
	localparam int CFG_IDX_W = 2;
	localparam int TDATA_W  = ((NUM_KEYS + 7) / 8) * 8;

	localparam logic [TYPE_W-1:0] TYPE_SHORT  = 2'd0;
	localparam logic [TYPE_W-1:0] TYPE_LONG   = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_REPEAT = 2'd2;
	localparam logic [TYPE_W-1:0] TYPE_NONE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_TYPES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 2'd3;

	localparam logic [TYPES_W-1:0] KEY_TYPES_RST = 10'd90;
	localparam logic [CNT_W-1:0]   DEBOUNCE_RST  = 8'd2;
	localparam logic [CNT_W-1:0]   HOLD_RST      = 8'd100;
	localparam logic [CNT_W-1:0]   REPEAT_RST    = 8'd30;
	localparam logic [CNT_W-1:0]   HOLD_MAX      = 8'd254;

	// Timing settings shared by every lane.
	typedef struct packed {
		logic [CNT_W-1:0] debounce;
		logic [CNT_W-1:0] hold_lim;
		logic [CNT_W-1:0] repeat_ticks;
	} timing_t;

endpackage

FILE: src/kdlpr_lane.sv
// One key lane: debounce counter, confirmed flag, hold and repeat counters.
// Depends on kdlpr_pkg for widths, key type codes and the timing struct.
module kdlpr_lane import kdlpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              pressed,
	input  logic [TYPE_W-1:0] kind,
	input  timing_t           timing,
	output logic              report
);

	logic [CNT_W-1:0] dbc_q, hold_q, rpt_q;
	logic             conf_q;
	logic [CNT_W-1:0] dbc_d, hold_d, rpt_d, hold_inc, rpt_inc;
	logic             conf_d;

	always_comb begin
		dbc_d    = dbc_q;
		conf_d   = conf_q;
		hold_d   = hold_q;
		rpt_d    = rpt_q;
		report   = 1'b0;
		hold_inc = CNT_W'(hold_q + 1'b1);
		rpt_inc  = CNT_W'(rpt_q + 1'b1);

		if (pressed) begin
			if (dbc_q < timing.debounce) begin
				dbc_d = CNT_W'(dbc_q + 1'b1);
			end else begin
				conf_d = 1'b1;
			end
		end else begin
			report = conf_q && (kind == TYPE_SHORT);
			conf_d = 1'b0;
			dbc_d  = '0;
			hold_d = '0;
			rpt_d  = '0;
		end

		if (conf_d) begin
			case (kind)
				TYPE_LONG: begin
					// Count up to the limit, report once as it is reached and step past it.
					if (hold_q < timing.hold_lim) begin
						hold_d = hold_inc;
					end
					if (hold_d == timing.hold_lim) begin
						report = 1'b1;
						hold_d = CNT_W'(hold_d + 1'b1);
					end
				end
				TYPE_REPEAT: begin
					if (hold_q == '0) begin
						report = 1'b1;
						hold_d = CNT_W'(1);
					end else if (hold_q < timing.hold_lim) begin
						hold_d = hold_inc;
					end else if (rpt_inc >= timing.repeat_ticks) begin
						rpt_d  = '0;
						report = 1'b1;
					end else begin
						rpt_d = rpt_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbc_q  <= '0;
			conf_q <= 1'b0;
			hold_q <= '0;
			rpt_q  <= '0;
		end else if (advance) begin
			dbc_q  <= dbc_d;
			conf_q <= conf_d;
			hold_q <= hold_d;
			rpt_q  <= rpt_d;
		end
	end

endmodule

FILE: src/kdlpr_merge.sv
// Merge stage: gathers the lane reports into one word and holds it in an
// output register backed by a skid register. Depends on kdlpr_pkg.
module kdlpr_merge import kdlpr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [NUM_KEYS-1:0] lane_report,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [NUM_KEYS-1:0] out_mask
);

	logic [NUM_KEYS-1:0] main_q, skid_q, mask;
	logic                main_valid_q, skid_valid_q;

	// The report word is the OR-free concatenation of the per-lane pulses.
	assign mask      = lane_report;
	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_mask  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || out_ready) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || out_ready) begin
			main_q <= skid_valid_q ? skid_q : mask;
		end else if (push) begin
			skid_q <= mask;
		end
	end

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid word held while output register is empty");

	a_fill_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !main_valid_q) |=> (main_valid_q && main_q == $past(mask)))
		else $error("word pushed into empty stage not presented");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && main_valid_q && !out_ready) |=> (skid_valid_q && skid_q == $past(mask)))
		else $error("word pushed during stall not captured in skid");

	a_drain_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_ready) |=> (main_valid_q && main_q == $past(skid_q)))
		else $error("skid word not moved to output register");

endmodule

FILE: src/key_debounce_long_press_repeat.sv
// Top level of the key debounce, long-press and auto-repeat block.
// Depends on kdlpr_pkg, kdlpr_lane and kdlpr_merge.
//
// Usage: each word on the s_ stream is one tick of sampled key levels, bit k
// set when key k is pressed. For every accepted word the block returns one
// word on the m_ stream whose bit k pulses when key k reports on that tick.
// Short keys report on release after a confirmed press, long keys once when
// the hold count is reached, repeat keys on confirmation and then every
// repeat period after the hold.
// One lane per key updates its counters in the accepting cycle; the merged
// report mask is registered in the output register, or in the skid register
// while the receiver stalls. Throughput is one word per cycle, limited only
// by the output register. When the receiver stalls, one more word is taken
// into a skid register and then s_tready drops until the output drains.
// Settings are written on cfg_we with cfg_addr selecting key types, debounce,
// hold or repeat count; write them only while the stream is idle.
// Reset clears all key state to released, empties the output and loads the
// default settings.
module key_debounce_long_press_repeat import kdlpr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,   // [4:0] key_levels, rest zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,   // [4:0] report_mask, rest zero
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [TYPES_W-1:0]  key_types_q;
	logic [CNT_W-1:0]    debounce_q, hold_q, repeat_q;
	timing_t             timing;
	logic                accept;
	logic [NUM_KEYS-1:0] lane_report, out_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_types_q <= KEY_TYPES_RST;
			debounce_q  <= DEBOUNCE_RST;
			hold_q      <= HOLD_RST;
			repeat_q    <= REPEAT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_KEY_TYPES: key_types_q <= cfg_wdata[TYPES_W-1:0];
				REG_DEBOUNCE:  debounce_q  <= cfg_wdata[CNT_W-1:0];
				REG_HOLD:      hold_q      <= cfg_wdata[CNT_W-1:0];
				REG_REPEAT:    repeat_q    <= cfg_wdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A hold setting of 255 behaves as 254 so the hold counter never wraps.
	assign timing.debounce     = debounce_q;
	assign timing.hold_lim     = (hold_q > HOLD_MAX) ? HOLD_MAX : hold_q;
	assign timing.repeat_ticks = repeat_q;

	assign accept = s_tvalid && s_tready;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		kdlpr_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (accept),
			.pressed  (s_tdata[k]),
			.kind     (key_types_q[k*TYPE_W +: TYPE_W]),
			.timing   (timing),
			.report   (lane_report[k])
		);
	end

	kdlpr_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (accept),
		.lane_report (lane_report),
		.in_ready    (s_tready),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_mask    (out_mask)
	);

	assign m_tdata = TDATA_W'(out_mask);

endmodule
